// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the window generator rtl
// no dependencies; files that check their own logic include this header
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ===== hw/rtl/cswg_pkg.sv =====
// shared types, constants, microcode program and cosine table builder
// for the cosine-sum window generator; no dependencies
`timescale 1ns / 1ps

package cswg_pkg;

    // field widths
    localparam int SAMPLE_W   = 16;
    localparam int WEIGHT_W   = 18;
    localparam int WIN_W      = 18;
    localparam int MAX_LENGTH = 4096;
    localparam int POS_W      = $clog2(MAX_LENGTH);
    localparam int LEN_W      = POS_W + 1;
    localparam int TERM_CNT_W = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam int COS_W      = 16;

    // term handling
    localparam int MAX_TERMS   = 5;
    localparam int NUM_WEIGHTS = 5;
    localparam int TERMS_LIMIT = (MAX_TERMS < NUM_WEIGHTS) ? MAX_TERMS : NUM_WEIGHTS;

    // arithmetic
    localparam int DEF_PHASE_BITS       = 12;
    localparam int WEIGHT_FRACTION_BITS = 16;
    localparam int COS_SHIFT            = 15;
    localparam int PROD_W               = WEIGHT_W + COS_W;
    localparam int ACC_W                = PROD_W + 3;
    localparam int SCL_W                = SAMPLE_W + WIN_W;
    localparam int WIN_MAX_I            = 131071;
    localparam int WIN_MIN_I            = -131072;
    localparam int SMP_MAX_I            = 32767;
    localparam int SMP_MIN_I            = -32768;
    localparam longint ONE_Q            = longint'(1) << WEIGHT_FRACTION_BITS;
    localparam int LEN_ONE_WIN          = (ONE_Q > WIN_MAX_I) ? WIN_MAX_I : int'(ONE_Q);

    // reset values of the configuration registers
    localparam int RST_WIN_LEN  = 1024;
    localparam int RST_TERMS    = 2;
    localparam int RST_WEIGHT0  = 32768;
    localparam int RST_WEIGHT1  = -32768;
    localparam int RST_WEIGHT2  = 0;
    localparam int RST_WEIGHT3  = 0;
    localparam int RST_WEIGHT4  = 0;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_LENGTH = 3'd0,
        CFG_TERM_COUNT    = 3'd1,
        CFG_WEIGHT_ZERO   = 3'd2,
        CFG_WEIGHT_ONE    = 3'd3,
        CFG_WEIGHT_TWO    = 3'd4,
        CFG_WEIGHT_THREE  = 3'd5,
        CFG_WEIGHT_FOUR   = 3'd6
    } t_cfg_reg;

    // datapath micro-operations
    typedef enum logic [3:0] {
        OP_ACCEPT,
        OP_START_TERM,
        OP_DIV_STEP,
        OP_ROM_READ,
        OP_MAC,
        OP_ACC,
        OP_ROUND,
        OP_SCALE,
        OP_FINISH
    } t_uop;

    // jump conditions
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_SKIP_TERMS,
        COND_DIV_MORE,
        COND_OUT_BUSY,
        COND_IN_IDLE
    } t_ucond;

    localparam int UA_W = 4;
    typedef logic [UA_W-1:0] t_uaddr;

    // program step addresses
    localparam t_uaddr UA_START  = 4'd0;
    localparam t_uaddr UA_DIV    = 4'd1;
    localparam t_uaddr UA_ROM    = 4'd2;
    localparam t_uaddr UA_MAC    = 4'd3;
    localparam t_uaddr UA_ACC    = 4'd4;
    localparam t_uaddr UA_ROUND  = 4'd5;
    localparam t_uaddr UA_SCALE  = 4'd6;
    localparam t_uaddr UA_FINISH = 4'd7;
    localparam t_uaddr UA_IDLE   = 4'd8;
    localparam t_uaddr UA_LAST   = UA_IDLE;

    typedef struct packed {
        t_uop   op;
        t_ucond cond;
        t_uaddr target;
    } t_uword;

    // sequencer to datapath
    typedef struct packed {
        t_uop op;
        logic fire;
    } t_ctl;

    // datapath to sequencer
    typedef struct packed {
        logic div_more;
        logic skip_terms;
        logic out_busy;
    } t_stat;

    // control store: one word per step, fall through to the next step
    // unless the condition holds
    function automatic t_uword ucode(t_uaddr a);
        t_uword w;
        w = '{op: OP_ACCEPT, cond: COND_IN_IDLE, target: UA_IDLE};
        case (a)
            UA_START:  w = '{op: OP_START_TERM, cond: COND_SKIP_TERMS, target: UA_ROUND};
            UA_DIV:    w = '{op: OP_DIV_STEP, cond: COND_DIV_MORE, target: UA_DIV};
            UA_ROM:    w = '{op: OP_ROM_READ, cond: COND_NEVER, target: UA_START};
            UA_MAC:    w = '{op: OP_MAC, cond: COND_NEVER, target: UA_START};
            UA_ACC:    w = '{op: OP_ACC, cond: COND_ALWAYS, target: UA_START};
            UA_ROUND:  w = '{op: OP_ROUND, cond: COND_NEVER, target: UA_START};
            UA_SCALE:  w = '{op: OP_SCALE, cond: COND_NEVER, target: UA_START};
            UA_FINISH: w = '{op: OP_FINISH, cond: COND_OUT_BUSY, target: UA_FINISH};
            UA_IDLE:   w = '{op: OP_ACCEPT, cond: COND_IN_IDLE, target: UA_IDLE};
            default:   w = '{op: OP_ACCEPT, cond: COND_ALWAYS, target: UA_IDLE};
        endcase
        return w;
    endfunction

    // fixed-point constants for the cosine series (Q2.62)
    localparam logic [63:0] Q62_ONE = 64'h4000_0000_0000_0000;
    localparam logic [63:0] Q62_PI  = 64'hC90F_DAA2_2168_C235;

    // quarter-wave entry r: cosine magnitude in [31:16], sine magnitude in [15:0]
    // evaluated at elaboration only
    function automatic logic [31:0] cos_sin_mag(int unsigned pb, int unsigned r);
        logic [63:0]  pi_hi;
        logic [63:0]  pi_lo;
        logic [63:0]  theta;
        logic [63:0]  term;
        logic [63:0]  c;
        logic [63:0]  s;
        logic [63:0]  mag_c;
        logic [63:0]  mag_s;
        logic [127:0] wide;
        int unsigned  n;
        pi_hi = Q62_PI >> (pb - 1);
        pi_lo = Q62_PI & ((64'd1 << (pb - 1)) - 64'd1);
        theta = pi_hi * 64'(r) + ((pi_lo * 64'(r)) >> (pb - 1));
        term  = Q62_ONE;
        c     = Q62_ONE;
        s     = 64'd0;
        for (n = 1; n <= 40; n++) begin
            wide = {64'd0, term} * {64'd0, theta};
            term = wide[125:62] / 64'(n);
            case (n[1:0])
                2'd1:    s = s + term;
                2'd2:    c = c - term;
                2'd3:    s = s - term;
                default: c = c + term;
            endcase
        end
        if (c[63]) c = 64'd0;
        if (c > Q62_ONE) c = Q62_ONE;
        if (s[63]) s = 64'd0;
        if (s > Q62_ONE) s = Q62_ONE;
        mag_c = ((c >> 17) * 64'd32767 + (64'd1 << 44)) >> 45;
        mag_s = ((s >> 17) * 64'd32767 + (64'd1 << 44)) >> 45;
        return {mag_c[15:0], mag_s[15:0]};
    endfunction

endpackage

// ===== hw/rtl/cswg_if.sv =====
// handshake channels of the window generator: sample in, result out, config writes
// depends on cswg_pkg
`timescale 1ns / 1ps

interface cswg_in_if import cswg_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       restart;

    modport source (output valid, sample_in, restart, input ready);
    modport sink   (input valid, sample_in, restart, output ready);
endinterface

interface cswg_out_if import cswg_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] windowed_sample;
    logic signed [WIN_W-1:0]    window_value;
    logic [POS_W-1:0]           position;
    logic                       frame_end;

    modport source (output valid, windowed_sample, window_value, position, frame_end,
                    input ready);
    modport sink   (input valid, windowed_sample, window_value, position, frame_end,
                    output ready);
endinterface

interface cswg_cfg_if import cswg_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/cswg_cos_rom.sv =====
// full-wave cosine table built from quarter-wave cosine and sine magnitudes,
// registered read; depends on cswg_pkg
`timescale 1ns / 1ps

module cswg_cos_rom import cswg_pkg::*; #(
    parameter int PHASE_BITS = DEF_PHASE_BITS
) (
    input  logic                    i_clk,
    input  logic [PHASE_BITS-1:0]   i_addr,
    output logic signed [COS_W-1:0] o_data
);

    localparam int QUARTER = 2 ** (PHASE_BITS - 2);

    logic [COS_W-1:0] tab_c [QUARTER];
    logic [COS_W-1:0] tab_s [QUARTER];

    // constant quarter-wave tables
    for (genvar g = 0; g < QUARTER; g++) begin : g_tab
        localparam logic [31:0] CS = cos_sin_mag(PHASE_BITS, g);
        assign tab_c[g] = CS[31:16];
        assign tab_s[g] = CS[15:0];
    end

    logic [1:0]            quad;
    logic [PHASE_BITS-3:0] ridx;
    logic [COS_W-1:0]      mag;
    logic                  neg;
    logic signed [COS_W-1:0] r_data;

    // quadrant selects table and sign
    assign quad = i_addr[PHASE_BITS-1:PHASE_BITS-2];
    assign ridx = i_addr[PHASE_BITS-3:0];
    assign mag  = quad[0] ? tab_s[ridx] : tab_c[ridx];
    assign neg  = (quad == 2'd1) || (quad == 2'd2);

    // registered read
    always_ff @(posedge i_clk) begin
        r_data <= neg ? -$signed(mag) : $signed(mag);
    end

    assign o_data = r_data;

endmodule

// ===== hw/rtl/cswg_useq.sv =====
// microcode sequencer: step counter, control store lookup and conditional jumps
// depends on cswg_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cswg_useq import cswg_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_ctl  o_ctl
);

    t_uaddr r_upc;
    t_uaddr n_upc;
    t_uword word;
    logic   jump;
    logic   fire;

    assign word = ucode(r_upc);

    // jump condition and op qualifier
    always_comb begin
        case (word.cond)
            COND_NEVER:      jump = 1'b0;
            COND_ALWAYS:     jump = 1'b1;
            COND_SKIP_TERMS: jump = i_stat.skip_terms;
            COND_DIV_MORE:   jump = i_stat.div_more;
            COND_OUT_BUSY:   jump = i_stat.out_busy;
            COND_IN_IDLE:    jump = !i_in_valid;
            default:         jump = 1'b0;
        endcase
        case (word.op)
            OP_ACCEPT: fire = i_in_valid;
            OP_FINISH: fire = !i_stat.out_busy;
            default:   fire = 1'b1;
        endcase
        if (jump) begin
            n_upc = word.target;
        end else if (r_upc == UA_LAST) begin
            n_upc = UA_START;
        end else begin
            n_upc = r_upc + t_uaddr'(1);
        end
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= UA_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_in_ready = (word.op == OP_ACCEPT);
    assign o_ctl      = '{op: word.op, fire: fire};

    `ASSERT_CLK(a_accept_starts, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> (r_upc == UA_START), "accepted beat did not start the term loop")
    `ASSERT_CLK(a_finish_to_idle, i_clk, i_rst_n, (o_ctl.op == OP_FINISH && o_ctl.fire) |=> (r_upc == UA_IDLE), "finish did not return to idle")
    `ASSERT_NEVER(a_upc_range, i_clk, i_rst_n, r_upc > UA_LAST, "step counter left the program")

endmodule

// ===== hw/rtl/cswg_datapath.sv =====
// datapath: config registers, position counter, phase divider, multiply-accumulate,
// rounding and output register; depends on cswg_pkg, cswg_if and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cswg_datapath import cswg_pkg::*; #(
    parameter int PHASE_BITS = DEF_PHASE_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_ctl                       i_ctl,
    output t_stat                      o_stat,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_restart,
    output logic [PHASE_BITS-1:0]      o_rom_addr,
    input  logic signed [COS_W-1:0]    i_rom_data,
    cswg_cfg_if.sink                   i_cfg,
    cswg_out_if.source                 o_out
);

    localparam int DCNT_W = $clog2(PHASE_BITS);
    localparam logic signed [ACC_W-1:0] ACC_BIAS  = ACC_W'(1 << (COS_SHIFT - 1));
    localparam logic signed [ACC_W-1:0] WIN_MAX_A = ACC_W'(WIN_MAX_I);
    localparam logic signed [ACC_W-1:0] WIN_MIN_A = ACC_W'(WIN_MIN_I);
    localparam logic signed [WIN_W-1:0] WIN_ONE   = WIN_W'(LEN_ONE_WIN);
    localparam logic signed [SCL_W:0]   SCL_BIAS  = (SCL_W + 1)'(1 << (WEIGHT_FRACTION_BITS - 1));
    localparam logic signed [SCL_W:0]   SMP_MAX_A = (SCL_W + 1)'(SMP_MAX_I);
    localparam logic signed [SCL_W:0]   SMP_MIN_A = (SCL_W + 1)'(SMP_MIN_I);

    // configuration registers
    logic [LEN_W-1:0]           r_win_len;
    logic [TERM_CNT_W-1:0]      r_term_cnt;
    logic signed [WEIGHT_W-1:0] r_weight [NUM_WEIGHTS];

    // control state
    logic [POS_W-1:0] r_count;
    logic             r_out_valid;

    // working registers
    logic [POS_W-1:0]           r_pos;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic [POS_W-1:0]           r_m;
    logic [POS_W-1:0]           r_rem;
    logic [PHASE_BITS-1:0]      r_quot;
    logic [DCNT_W-1:0]          r_dcnt;
    logic [TERM_CNT_W-1:0]      r_term;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [WIN_W-1:0]    r_win;
    logic signed [SCL_W-1:0]    r_scaled;

    // output register
    logic signed [SAMPLE_W-1:0] r_out_sample;
    logic signed [WIN_W-1:0]    r_out_win;
    logic [POS_W-1:0]           r_out_pos;
    logic                       r_out_end;

    logic [LEN_W-1:0]           len_eff;
    logic [TERM_CNT_W-1:0]      terms_eff;
    logic                       len_one;
    logic                       out_busy;
    logic [POS_W-1:0]           pos_sel;
    logic [POS_W-1:0]           pos_ok;
    logic [LEN_W-1:0]           pos_inc;
    logic [POS_W-1:0]           n_count;
    logic [LEN_W-1:0]           div_t;
    logic                       div_ge;
    logic [LEN_W-1:0]           m_sum;
    logic [POS_W-1:0]           m_next;
    logic signed [WEIGHT_W-1:0] weight_sel;
    logic signed [ACC_W-1:0]    acc_bias;
    logic signed [ACC_W-1:0]    acc_rnd;
    logic signed [WIN_W-1:0]    win_sat;
    logic signed [SCL_W:0]      scl_bias;
    logic signed [SCL_W:0]      scl_rnd;
    logic signed [SAMPLE_W-1:0] smp_sat;
    logic                       step;

    assign step = i_ctl.fire;

    // effective length and term count
    always_comb begin
        if (r_win_len == '0) begin
            len_eff = LEN_W'(1);
        end else if (r_win_len > LEN_W'(MAX_LENGTH)) begin
            len_eff = LEN_W'(MAX_LENGTH);
        end else begin
            len_eff = r_win_len;
        end
        terms_eff = (r_term_cnt > TERM_CNT_W'(TERMS_LIMIT)) ? TERM_CNT_W'(TERMS_LIMIT)
                                                            : r_term_cnt;
    end

    assign len_one  = (len_eff == LEN_W'(1));
    assign out_busy = r_out_valid && !o_out.ready;

    // position for the incoming beat and the counter after it
    always_comb begin
        pos_sel = i_restart ? '0 : r_count;
        pos_ok  = (LEN_W'(pos_sel) < len_eff) ? pos_sel : '0;
        pos_inc = LEN_W'(pos_ok) + LEN_W'(1);
        n_count = (pos_inc >= len_eff) ? '0 : pos_inc[POS_W-1:0];
    end

    // one restoring division step: phase = m * 2^PHASE_BITS / len
    assign div_t  = {r_rem, 1'b0};
    assign div_ge = (div_t >= len_eff);

    // next harmonic base: (m + pos) mod len, both below len
    always_comb begin
        m_sum  = LEN_W'(r_m) + LEN_W'(r_pos);
        m_next = (m_sum >= len_eff) ? POS_W'(m_sum - len_eff) : m_sum[POS_W-1:0];
    end

    // weight of the current term
    always_comb begin
        case (r_term)
            3'd0:    weight_sel = r_weight[0];
            3'd1:    weight_sel = r_weight[1];
            3'd2:    weight_sel = r_weight[2];
            3'd3:    weight_sel = r_weight[3];
            3'd4:    weight_sel = r_weight[4];
            default: weight_sel = '0;
        endcase
    end

    // window round and saturate; a length of one forces unity
    always_comb begin
        acc_bias = r_acc + ACC_BIAS;
        acc_rnd  = acc_bias >>> COS_SHIFT;
        if (len_one) begin
            win_sat = WIN_ONE;
        end else if (acc_rnd > WIN_MAX_A) begin
            win_sat = WIN_MAX_A[WIN_W-1:0];
        end else if (acc_rnd < WIN_MIN_A) begin
            win_sat = WIN_MIN_A[WIN_W-1:0];
        end else begin
            win_sat = acc_rnd[WIN_W-1:0];
        end
    end

    // windowed sample round and saturate
    always_comb begin
        scl_bias = (SCL_W + 1)'(r_scaled) + SCL_BIAS;
        scl_rnd  = scl_bias >>> WEIGHT_FRACTION_BITS;
        if (scl_rnd > SMP_MAX_A) begin
            smp_sat = SMP_MAX_A[SAMPLE_W-1:0];
        end else if (scl_rnd < SMP_MIN_A) begin
            smp_sat = SMP_MIN_A[SAMPLE_W-1:0];
        end else begin
            smp_sat = scl_rnd[SAMPLE_W-1:0];
        end
    end

    // configuration writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len   <= LEN_W'(RST_WIN_LEN);
            r_term_cnt  <= TERM_CNT_W'(RST_TERMS);
            r_weight[0] <= WEIGHT_W'(RST_WEIGHT0);
            r_weight[1] <= WEIGHT_W'(RST_WEIGHT1);
            r_weight[2] <= WEIGHT_W'(RST_WEIGHT2);
            r_weight[3] <= WEIGHT_W'(RST_WEIGHT3);
            r_weight[4] <= WEIGHT_W'(RST_WEIGHT4);
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (t_cfg_reg'(i_cfg.index))
                CFG_WINDOW_LENGTH: r_win_len   <= i_cfg.data[LEN_W-1:0];
                CFG_TERM_COUNT:    r_term_cnt  <= i_cfg.data[TERM_CNT_W-1:0];
                CFG_WEIGHT_ZERO:   r_weight[0] <= $signed(i_cfg.data[WEIGHT_W-1:0]);
                CFG_WEIGHT_ONE:    r_weight[1] <= $signed(i_cfg.data[WEIGHT_W-1:0]);
                CFG_WEIGHT_TWO:    r_weight[2] <= $signed(i_cfg.data[WEIGHT_W-1:0]);
                CFG_WEIGHT_THREE:  r_weight[3] <= $signed(i_cfg.data[WEIGHT_W-1:0]);
                CFG_WEIGHT_FOUR:   r_weight[4] <= $signed(i_cfg.data[WEIGHT_W-1:0]);
                default: ;
            endcase
        end
    end

    // position counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.op == OP_ACCEPT && step) begin
                r_count <= n_count;
            end
            if (i_ctl.op == OP_FINISH && step) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers, one micro-op per cycle while the sequencer fires
    always_ff @(posedge i_clk) begin
        if (step) begin
            case (i_ctl.op)
                OP_ACCEPT: begin
                    r_pos    <= pos_ok;
                    r_sample <= i_sample;
                    r_m      <= '0;
                    r_term   <= '0;
                    r_acc    <= '0;
                end
                OP_START_TERM: begin
                    r_rem  <= r_m;
                    r_quot <= '0;
                    r_dcnt <= '0;
                end
                OP_DIV_STEP: begin
                    r_rem  <= div_ge ? POS_W'(div_t - len_eff) : div_t[POS_W-1:0];
                    r_quot <= {r_quot[PHASE_BITS-2:0], div_ge};
                    r_dcnt <= r_dcnt + DCNT_W'(1);
                end
                OP_MAC: begin
                    r_prod <= weight_sel * i_rom_data;
                end
                OP_ACC: begin
                    r_acc  <= r_acc + ACC_W'(r_prod);
                    r_m    <= m_next;
                    r_term <= r_term + TERM_CNT_W'(1);
                end
                OP_ROUND: begin
                    r_win <= win_sat;
                end
                OP_SCALE: begin
                    r_scaled <= r_sample * r_win;
                end
                OP_FINISH: begin
                    r_out_sample <= smp_sat;
                    r_out_win    <= r_win;
                    r_out_pos    <= r_pos;
                    r_out_end    <= (LEN_W'(r_pos) == (len_eff - LEN_W'(1)));
                end
                default: ;
            endcase
        end
    end

    assign o_rom_addr = r_quot;

    assign o_stat = '{div_more:   (r_dcnt != DCNT_W'(PHASE_BITS - 1)),
                      skip_terms: (len_one || (r_term >= terms_eff)),
                      out_busy:   out_busy};

    assign o_out.valid           = r_out_valid;
    assign o_out.windowed_sample = r_out_sample;
    assign o_out.window_value    = r_out_win;
    assign o_out.position        = r_out_pos;
    assign o_out.frame_end       = r_out_end;

    `ASSERT_CLK(a_rem_below_len, i_clk, i_rst_n, (i_ctl.op == OP_DIV_STEP) |-> (LEN_W'(r_rem) < len_eff), "divider remainder not below length")
    `ASSERT_CLK(a_base_below_len, i_clk, i_rst_n, (i_ctl.op == OP_START_TERM) |-> (LEN_W'(r_m) < len_eff), "harmonic base not reduced by length")
    `ASSERT_CLK(a_finish_loads_out, i_clk, i_rst_n, (i_ctl.op == OP_FINISH && i_ctl.fire) |=> o_out.valid, "finished result not presented")

endmodule

// ===== hw/rtl/cosine_sum_window_generator_core.sv =====
// top level of the cosine-sum window generator: sequencer, datapath, cosine table
// depends on cswg_pkg, cswg_if, cswg_useq, cswg_datapath, cswg_cos_rom
`timescale 1ns / 1ps

// Usage
//  i_in  : sample beats (sample_in, restart); a beat moves when valid and ready are high.
//  o_out : one result beat per sample (windowed_sample, window_value, position, frame_end).
//  i_cfg : register writes (index, data), always ready; write only while the block is idle.
//  One sample is worked on at a time. After acceptance, each effective term (none for a
//  length of one) runs a term start, a one-bit-per-cycle phase divider, a registered
//  cosine table read, one multiply and one accumulate; the window is then rounded, the
//  sample scaled and the result loaded into the output register, all stepped by the
//  microcode program.
//  Ready is high only in the idle step of the program, so the next sample is taken no
//  earlier than the cycle after the previous result is loaded into the output register.
//  While the receiver stalls, the result waits in the output register and the next sample
//  is still accepted and computed; the program then holds at its finish step until the
//  output register is free.
//  Reset (synchronous, active low) restores the Hann defaults, clears the position counter
//  and drops any pending result. No clearing pass is needed.
module cosine_sum_window_generator_core import cswg_pkg::*; #(
    parameter int PHASE_BITS = DEF_PHASE_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cswg_in_if.sink     i_in,
    cswg_out_if.source  o_out,
    cswg_cfg_if.sink    i_cfg
);

    t_ctl                    ctl;
    t_stat                   stat;
    logic                    in_ready;
    logic [PHASE_BITS-1:0]   rom_addr;
    logic signed [COS_W-1:0] rom_data;

    assign i_in.ready = in_ready;

    // program sequencer
    cswg_useq u_useq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_ctl      (ctl)
    );

    // arithmetic and registers
    cswg_datapath #(
        .PHASE_BITS (PHASE_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .o_stat     (stat),
        .i_sample   (i_in.sample_in),
        .i_restart  (i_in.restart),
        .o_rom_addr (rom_addr),
        .i_rom_data (rom_data),
        .i_cfg      (i_cfg),
        .o_out      (o_out)
    );

    // cosine table
    cswg_cos_rom #(
        .PHASE_BITS (PHASE_BITS)
    ) u_cos_rom (
        .i_clk  (i_clk),
        .i_addr (rom_addr),
        .o_data (rom_data)
    );

endmodule

// ===== bench/cswg_window_checker.sv =====
// scoreboard for the cosine-sum window generator: watches the config, sample and result
// channels, predicts every result beat and compares it field by field
// depends on cswg_pkg and cswg_if
`timescale 1ns / 1ps

module cswg_window_checker import cswg_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    cswg_in_if   i_in,
    cswg_out_if  i_out,
    cswg_cfg_if  i_cfg,
    input  logic i_drain_done,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);

    localparam logic [63:0] UNIT_Q62 = 64'h4000_0000_0000_0000;
    localparam logic [63:0] PI_Q62   = 64'hC90F_DAA2_2168_C235;
    localparam int          PH_SHIFT = DEF_PHASE_BITS - 1;
    localparam int          QUARTER  = 1 << (DEF_PHASE_BITS - 2);
    localparam int          PH_MASK  = (1 << DEF_PHASE_BITS) - 1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] windowed;
        logic signed [WIN_W-1:0]    win;
        logic [POS_W-1:0]           pos;
        logic                       frame_end;
    } t_window_beat;

    int                          cos_table [0:(1 << DEF_PHASE_BITS) - 1];
    logic [LEN_W-1:0]            win_len;
    logic [TERM_CNT_W-1:0]       term_cnt;
    logic signed [WEIGHT_W-1:0]  weight [NUM_WEIGHTS];
    int unsigned                 frame_pos;
    t_window_beat                expected_q [$];
    int                          fail_cnt;
    int                          checked_cnt;

    assign o_fail_count = fail_cnt;
    assign o_checked    = checked_cnt;

    // clamp a Q2.62 series value into 0..1 and scale it to a 15-bit magnitude
    function automatic int q62_to_q15(logic [63:0] v);
        logic [63:0] m;
        if (v[63]) v = 64'd0;
        if (v > UNIT_Q62) v = UNIT_Q62;
        m = ((v >> 17) * 64'd32767 + (64'd1 << 44)) >> 45;
        return int'(m);
    endfunction

    // cosine table from a 40-term taylor series per quarter-wave point
    initial begin
        logic [63:0]  pi_hi;
        logic [63:0]  pi_lo;
        logic [63:0]  theta;
        logic [63:0]  term;
        logic [63:0]  c_sum;
        logic [63:0]  s_sum;
        logic [127:0] wide;
        int unsigned  r;
        int unsigned  n;
        int           mc;
        int           ms;
        pi_hi = PI_Q62 >> PH_SHIFT;
        pi_lo = PI_Q62 & ((64'd1 << PH_SHIFT) - 64'd1);
        for (r = 0; r < QUARTER; r++) begin
            theta = pi_hi * 64'(r) + ((pi_lo * 64'(r)) >> PH_SHIFT);
            term  = UNIT_Q62;
            c_sum = UNIT_Q62;
            s_sum = 64'd0;
            for (n = 1; n <= 40; n++) begin
                wide = {64'd0, term} * {64'd0, theta};
                term = wide[125:62] / 64'(n);
                case (n % 4)
                    1:       s_sum = s_sum + term;
                    2:       c_sum = c_sum - term;
                    3:       s_sum = s_sum - term;
                    default: c_sum = c_sum + term;
                endcase
            end
            mc = q62_to_q15(c_sum);
            ms = q62_to_q15(s_sum);
            cos_table[r]               = mc;
            cos_table[QUARTER + r]     = -ms;
            cos_table[2 * QUARTER + r] = -mc;
            cos_table[3 * QUARTER + r] = ms;
        end
    end

    // window weight and scaled sample for one beat; advances the frame position
    function automatic t_window_beat predict_window(logic signed [SAMPLE_W-1:0] smp,
                                                    logic restart_pos);
        t_window_beat b;
        int unsigned  len;
        int unsigned  terms;
        int unsigned  pos;
        int unsigned  ph;
        int unsigned  j;
        longint       acc;
        longint       win;
        longint       prod;
        len = win_len;
        if (len == 0) len = 1;
        if (len > MAX_LENGTH) len = MAX_LENGTH;
        terms = term_cnt;
        if (terms > TERMS_LIMIT) terms = TERMS_LIMIT;
        pos = restart_pos ? 0 : frame_pos;
        // length lowered under a running counter restarts the frame
        if (pos >= len) pos = 0;
        if (len == 1) begin
            win = longint'(1) << WEIGHT_FRACTION_BITS;
        end else begin
            acc = 0;
            for (j = 0; j < terms; j++) begin
                ph  = (((pos * j) % len) << DEF_PHASE_BITS) / len;
                acc = acc + longint'(weight[j]) * longint'(cos_table[ph & PH_MASK]);
            end
            win = (acc + (longint'(1) << 14)) >>> 15;
        end
        if (win > WIN_MAX_I) win = WIN_MAX_I;
        if (win < WIN_MIN_I) win = WIN_MIN_I;
        prod = (longint'(smp) * win + (longint'(1) << (WEIGHT_FRACTION_BITS - 1)))
               >>> WEIGHT_FRACTION_BITS;
        if (prod > SMP_MAX_I) prod = SMP_MAX_I;
        if (prod < SMP_MIN_I) prod = SMP_MIN_I;
        b.windowed  = prod[SAMPLE_W-1:0];
        b.win       = win[WIN_W-1:0];
        b.pos       = pos[POS_W-1:0];
        b.frame_end = (pos == len - 1);
        frame_pos   = (pos + 1 >= len) ? 0 : pos + 1;
        return b;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns  mismatch: %s", $time, what);
        fail_cnt++;
    endtask

    // track register writes, check result beats, queue predictions for sample beats
    always @(posedge i_clk) begin
        t_window_beat exp_b;
        if (!i_rst_n) begin
            win_len   = LEN_W'(RST_WIN_LEN);
            term_cnt  = TERM_CNT_W'(RST_TERMS);
            weight[0] = WEIGHT_W'(RST_WEIGHT0);
            weight[1] = WEIGHT_W'(RST_WEIGHT1);
            weight[2] = WEIGHT_W'(RST_WEIGHT2);
            weight[3] = WEIGHT_W'(RST_WEIGHT3);
            weight[4] = WEIGHT_W'(RST_WEIGHT4);
            frame_pos = 0;
            expected_q.delete();
        end else begin
            if (i_cfg.valid === 1'b1 && i_cfg.ready === 1'b1) begin
                case (t_cfg_reg'(i_cfg.index))
                    CFG_WINDOW_LENGTH: win_len   = i_cfg.data[LEN_W-1:0];
                    CFG_TERM_COUNT:    term_cnt  = i_cfg.data[TERM_CNT_W-1:0];
                    CFG_WEIGHT_ZERO:   weight[0] = i_cfg.data;
                    CFG_WEIGHT_ONE:    weight[1] = i_cfg.data;
                    CFG_WEIGHT_TWO:    weight[2] = i_cfg.data;
                    CFG_WEIGHT_THREE:  weight[3] = i_cfg.data;
                    CFG_WEIGHT_FOUR:   weight[4] = i_cfg.data;
                    default: ;
                endcase
            end
            if (i_out.valid === 1'b1 && i_out.ready === 1'b1) begin
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("result beat with no sample outstanding (pos %0d)",
                                              i_out.position));
                end else begin
                    exp_b = expected_q.pop_front();
                    checked_cnt++;
                    if (i_out.windowed_sample !== exp_b.windowed)
                        report_mismatch($sformatf("windowed_sample %0d, expected %0d (pos %0d)",
                                        i_out.windowed_sample, exp_b.windowed, exp_b.pos));
                    if (i_out.window_value !== exp_b.win)
                        report_mismatch($sformatf("window_value %0d, expected %0d (pos %0d)",
                                        i_out.window_value, exp_b.win, exp_b.pos));
                    if (i_out.position !== exp_b.pos)
                        report_mismatch($sformatf("position %0d, expected %0d",
                                        i_out.position, exp_b.pos));
                    if (i_out.frame_end !== exp_b.frame_end)
                        report_mismatch($sformatf("frame_end %0b, expected %0b (pos %0d)",
                                        i_out.frame_end, exp_b.frame_end, exp_b.pos));
                end
            end
            if (i_in.valid === 1'b1 && i_in.ready === 1'b1)
                expected_q.push_back(predict_window(i_in.sample_in, i_in.restart));
            if (i_drain_done && expected_q.size() != 0)
                report_mismatch($sformatf("%0d expected results never arrived",
                                          expected_q.size()));
        end
        o_pending <= expected_q.size();
    end

    initial begin
        fail_cnt    = 0;
        checked_cnt = 0;
        frame_pos   = 0;
    end

endmodule

// ===== bench/cosine_sum_window_generator_core_tb.sv =====
// testbench top for the cosine-sum window generator: clock, reset, register settings,
// sample stimulus, result back-pressure and verdict
// depends on cswg_pkg, cswg_if, the core and cswg_window_checker
`timescale 1ns / 1ps

module cosine_sum_window_generator_core_tb import cswg_pkg::*; ();

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int RANDOM_PHASES   = 12;
    localparam int ITEMS_PER_PHASE = 155;
    localparam int SETTLE_CYCLES   = 4;
    localparam int DRAIN_CYCLES    = 100;

    // flat-top weights in Q2.16
    localparam int FT_W0 = 14128;
    localparam int FT_W1 = -27305;
    localparam int FT_W2 = 18171;
    localparam int FT_W3 = -5477;
    localparam int FT_W4 = 455;

    logic i_clk;
    logic i_rst_n;
    logic drain_done;
    bit   no_idle;
    int   fail_cnt;
    int   pending;
    int   checked;
    int   samples_sent;
    int   settings_cnt;
    int   cycle_cnt;
    int   out_hold;

    cswg_in_if  in_ch ();
    cswg_out_if out_ch ();
    cswg_cfg_if cfg_ch ();

    cosine_sum_window_generator_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    cswg_window_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg        (cfg_ch),
        .i_drain_done (drain_done),
        .o_fail_count (fail_cnt),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still outstanding",
                     cycle_cnt, pending);
            $display("FAIL");
            $finish;
        end
    end

    // result back-pressure: ready drops at random after an accepted beat unless no_idle
    always @(posedge i_clk) begin : out_ready_ctl
        int draw;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            out_hold     <= 0;
        end else if (out_ch.valid && out_ch.ready) begin
            draw = no_idle ? 0 : $urandom_range(0, 3);
            out_ch.ready <= (draw == 0);
            out_hold     <= (draw == 0) ? 0 : draw - 1;
        end else if (out_ch.valid && !out_ch.ready) begin
            if (out_hold == 0)
                out_ch.ready <= 1'b1;
            else
                out_hold <= out_hold - 1;
        end
    end

    // one sample beat, then a random gap with valid low unless no_idle is set
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp, input logic restart_pos);
        int gap;
        in_ch.valid     <= 1'b1;
        in_ch.sample_in <= smp;
        in_ch.restart   <= restart_pos;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        samples_sent++;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // stop sending and wait until every result beat is back
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_beat(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
    endtask

    // write all seven registers; caller has settled the block
    task automatic program_window(input int len, input int terms, input int w0, input int w1,
                                  input int w2, input int w3, input int w4);
        cfg_beat(CFG_WINDOW_LENGTH, CFG_DATA_W'(len));
        cfg_beat(CFG_TERM_COUNT, CFG_DATA_W'(terms));
        cfg_beat(CFG_WEIGHT_ZERO, CFG_DATA_W'(w0));
        cfg_beat(CFG_WEIGHT_ONE, CFG_DATA_W'(w1));
        cfg_beat(CFG_WEIGHT_TWO, CFG_DATA_W'(w2));
        cfg_beat(CFG_WEIGHT_THREE, CFG_DATA_W'(w3));
        cfg_beat(CFG_WEIGHT_FOUR, CFG_DATA_W'(w4));
        cfg_ch.valid <= 1'b0;
        settings_cnt++;
    endtask

    function automatic int rand_weight();
        return int'($urandom_range(0, 262143)) - 131072;
    endfunction

    initial begin
        int ph;
        int k;
        int len;
        int terms;
        int style;
        int restart_odds;
        int w0;
        int w1;
        int w2;
        int w3;
        int w4;
        logic signed [SAMPLE_W-1:0] smp;

        cycle_cnt    = 0;
        samples_sent = 0;
        settings_cnt = 0;
        no_idle      = 1'b0;
        i_rst_n         <= 1'b0;
        drain_done      <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.sample_in <= '0;
        in_ch.restart   <= 1'b0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= CFG_WINDOW_LENGTH;
        cfg_ch.data     <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset hann window, sample extremes
        send_sample(16'sd32767, 1'b1);
        send_sample(-16'sd32768, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd1, 1'b0);

        // length one passes the sample through
        settle();
        program_window(1, 5, 131071, 131071, 131071, 131071, 131071);
        send_sample(16'sd32767, 1'b0);
        send_sample(-16'sd32768, 1'b1);

        // length zero behaves as length one
        settle();
        program_window(0, 1, -131072, -131072, -131072, -131072, -131072);
        send_sample(-16'sd32768, 1'b0);

        // oversized length and term count clamp; window saturates high
        settle();
        program_window(8191, 7, 131071, 131071, 131071, 131071, 131071);
        send_sample(-16'sd32768, 1'b1);
        send_sample(16'sd12345, 1'b0);

        // no terms gives a zero window
        settle();
        program_window(16, 0, 32768, -32768, 0, 0, 0);
        send_sample(16'sd20000, 1'b0);

        // most negative weights saturate the window low
        settle();
        program_window(16, 5, -131072, -131072, -131072, -131072, -131072);
        send_sample(16'sd32767, 1'b1);
        send_sample(-16'sd32768, 1'b0);

        // length lowered below a running counter
        settle();
        program_window(8, 2, 32768, -32768, 0, 0, 0);
        for (k = 0; k < 6; k++)
            send_sample(SAMPLE_W'($urandom_range(0, 65535)), k == 0);
        settle();
        program_window(4, 2, 32768, -32768, 0, 0, 0);
        send_sample(16'sd30000, 1'b0);
        send_sample(-16'sd30000, 1'b0);

        // random phases, one register setting each
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            settle();
            no_idle = (ph % 4 == 1);
            case (ph % 6)
                0: len = $urandom_range(2, 16);
                1: len = $urandom_range(17, 256);
                2: len = $urandom_range(2, 4096);
                3: begin
                    case ($urandom_range(0, 4))
                        0: len = 1;
                        1: len = 2;
                        2: len = 4096;
                        3: len = 0;
                        default: len = $urandom_range(4097, 8191);
                    endcase
                end
                4: len = $urandom_range(2, 64);
                default: len = $urandom_range(3, 40);
            endcase
            terms = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 5) : $urandom_range(0, 7);
            style = $urandom_range(0, 3);
            case (style)
                0: begin
                    w0 = 32768; w1 = -32768; w2 = 0; w3 = 0; w4 = 0;
                end
                1: begin
                    w0 = FT_W0; w1 = FT_W1; w2 = FT_W2; w3 = FT_W3; w4 = FT_W4;
                end
                2: begin
                    w0 = rand_weight(); w1 = rand_weight(); w2 = rand_weight();
                    w3 = rand_weight(); w4 = rand_weight();
                end
                default: begin
                    w0 = rand_weight() / 4; w1 = rand_weight() / 4; w2 = rand_weight() / 4;
                    w3 = rand_weight() / 4; w4 = rand_weight() / 4;
                end
            endcase
            program_window(len, terms, w0, w1, w2, w3, w4);
            restart_odds = (ph % 5 == 2) ? 4 : 32;
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                case ($urandom_range(0, 7))
                    0:       smp = (k % 2) ? 16'sd32767 : -16'sd32768;
                    default: smp = SAMPLE_W'($urandom_range(0, 65535));
                endcase
                send_sample(smp, $urandom_range(0, restart_odds - 1) == 0);
            end
        end

        // drain and close
        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        drain_done <= 1'b1;
        @(posedge i_clk);
        drain_done <= 1'b0;
        @(posedge i_clk);
        $display("%0d samples sent, %0d result beats compared, %0d mismatches",
                 samples_sent, checked, fail_cnt);
        $display("%0d register settings: lengths 0 to 8191, term counts 0 to 7, hann, flat-top,"
                 , settings_cnt);
        $display("  random and saturating weights, restarts and lowered lengths");
        if (fail_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/cswg_pkg.sv
hw/rtl/cswg_if.sv
hw/rtl/cswg_cos_rom.sv
hw/rtl/cswg_useq.sv
hw/rtl/cswg_datapath.sv
hw/rtl/cosine_sum_window_generator_core.sv
bench/cswg_window_checker.sv
bench/cosine_sum_window_generator_core_tb.sv
